// ===== src/cca_pkg.sv =====
// ----------------------------------------------------------------------------
// cca_pkg
// Shared constants and controller/datapath interface types for the cluster
// chain allocator.
// ----------------------------------------------------------------------------
package cca_pkg;

	localparam int CLUSTERS = 4096;
	localparam int IDX_W    = $clog2(CLUSTERS);
	localparam int STEP_W   = IDX_W + 1;
	localparam int LINK_W   = 16;
	localparam int COUNT_W  = 13;

	localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
	localparam logic [LINK_W-1:0] LINK_EOC  = 16'hFFFF;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic scan_start;
		logic scan_next;
		logic found;
		logic link;
		logic set_fail;
		logic fw_fail_init;
		logic fw_issue;
		logic fw_step;
		logic out_load;
	} cca_cmd_t;

	typedef struct packed {
		logic in_free;
		logic in_count_zero;
		logic rd_free;
		logic scan_last;
		logic last_alloc;
		logic have;
		logic fw_stop;
		logic next_eoc;
		logic clr_last;
		logic out_busy;
	} cca_stat_t;

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] res;
		if (idx == IDX_W'(CLUSTERS - 1)) begin
			res = '0;
		end else begin
			res = idx + IDX_W'(1);
		end
		return res;
	endfunction

endpackage

// ===== src/cca_ram.sv =====
// ----------------------------------------------------------------------------
// cca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/cca_ctrl.sv =====
// ----------------------------------------------------------------------------
// cca_ctrl
// Sequencer for table clearing, allocation scans, chain linking and free
// walks.
// ----------------------------------------------------------------------------
module cca_ctrl
	import cca_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  cca_stat_t stat,
	output cca_cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR      = 3'd0;
	localparam logic [2:0] ST_IDLE       = 3'd1;
	localparam logic [2:0] ST_SCAN_START = 3'd2;
	localparam logic [2:0] ST_SCAN       = 3'd3;
	localparam logic [2:0] ST_LINK       = 3'd4;
	localparam logic [2:0] ST_FW_CHECK   = 3'd5;
	localparam logic [2:0] ST_FW_READ    = 3'd6;
	localparam logic [2:0] ST_DONE       = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (stat.in_free) begin
						state_d = ST_FW_CHECK;
					end else if (stat.in_count_zero) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN_START;
					end
				end
			end
			ST_SCAN_START: begin
				cmd.scan_start = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.rd_free) begin
					cmd.found = 1'b1;
					state_d   = ST_LINK;
				end else if (stat.scan_last) begin
					cmd.set_fail = 1'b1;
					if (stat.have) begin
						cmd.fw_fail_init = 1'b1;
						state_d          = ST_FW_CHECK;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_LINK: begin
				cmd.link = 1'b1;
				if (stat.last_alloc) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN_START;
				end
			end
			ST_FW_CHECK: begin
				if (stat.fw_stop) begin
					state_d = ST_DONE;
				end else begin
					cmd.fw_issue = 1'b1;
					state_d      = ST_FW_READ;
				end
			end
			ST_FW_READ: begin
				cmd.fw_step = 1'b1;
				if (stat.next_eoc) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FW_CHECK;
				end
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/cca_dp.sv =====
// ----------------------------------------------------------------------------
// cca_dp
// Link table, scan and walk registers, search hint and result register.
// ----------------------------------------------------------------------------
module cca_dp
	import cca_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  cca_cmd_t              cmd,
	output cca_stat_t             stat
);

	logic [COUNT_W-1:0] in_count;
	logic [LINK_W-1:0]  in_start;

	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   hint_q;
	logic [IDX_W-1:0]   chk_idx_q;
	logic [IDX_W-1:0]   chk_cnt_q;
	logic [IDX_W-1:0]   found_q;
	logic [IDX_W-1:0]   prev_q;
	logic [IDX_W-1:0]   first_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] n_q;
	logic               have_q;
	logic               fail_q;
	logic [LINK_W-1:0]  cur_q;
	logic [STEP_W-1:0]  steps_q;
	logic               out_valid_q;
	logic               out_status_q;
	logic [LINK_W-1:0]  out_first_q;

	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [LINK_W-1:0]  wdata;
	logic [IDX_W-1:0]   raddr;
	logic [LINK_W-1:0]  rdata;

	assign in_count = s_tdata[COUNT_W-1:0];
	assign in_start = s_tdata[COUNT_W+LINK_W-1:COUNT_W];

	always_comb begin
		we    = 1'b0;
		waddr = chk_idx_q;
		wdata = LINK_FREE;
		if (cmd.clr_step) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (cmd.found) begin
			we    = 1'b1;
			wdata = LINK_EOC;
		end else if (cmd.link) begin
			we    = have_q;
			waddr = prev_q;
			wdata = LINK_W'(found_q);
		end else if (cmd.fw_step) begin
			we    = 1'b1;
			waddr = cur_q[IDX_W-1:0];
		end
	end

	always_comb begin
		if (cmd.scan_start) begin
			raddr = hint_q;
		end else if (cmd.fw_issue) begin
			raddr = cur_q[IDX_W-1:0];
		end else begin
			raddr = idx_next(chk_idx_q);
		end
	end

	cca_ram #(
		.WIDTH(LINK_W),
		.DEPTH(CLUSTERS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign stat.in_free       = s_tuser;
	assign stat.in_count_zero = (in_count == '0);
	assign stat.rd_free       = (rdata == LINK_FREE);
	assign stat.scan_last     = (chk_cnt_q == IDX_W'(CLUSTERS - 1));
	assign stat.last_alloc    = (n_q + COUNT_W'(1) == count_q);
	assign stat.have          = have_q;
	assign stat.fw_stop       = (cur_q >= LINK_W'(CLUSTERS)) ||
	                            (steps_q == STEP_W'(CLUSTERS));
	assign stat.next_eoc      = (rdata == LINK_EOC);
	assign stat.clr_last      = (clr_q == IDX_W'(CLUSTERS - 1));
	assign stat.out_busy      = out_valid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			hint_q      <= '0;
			have_q      <= 1'b0;
			fail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.load) begin
				have_q <= 1'b0;
				fail_q <= 1'b0;
			end
			if (cmd.found) begin
				hint_q <= idx_next(chk_idx_q);
			end
			if (cmd.link) begin
				have_q <= 1'b1;
			end
			if (cmd.set_fail) begin
				fail_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			count_q <= in_count;
			cur_q   <= in_start;
			steps_q <= '0;
			n_q     <= '0;
			first_q <= '0;
		end
		if (cmd.scan_start) begin
			chk_idx_q <= hint_q;
			chk_cnt_q <= '0;
		end
		if (cmd.scan_next) begin
			chk_idx_q <= idx_next(chk_idx_q);
			chk_cnt_q <= chk_cnt_q + IDX_W'(1);
		end
		if (cmd.found) begin
			found_q <= chk_idx_q;
			if (!have_q) begin
				first_q <= chk_idx_q;
			end
		end
		if (cmd.link) begin
			prev_q <= found_q;
			n_q    <= n_q + COUNT_W'(1);
		end
		if (cmd.fw_fail_init) begin
			cur_q   <= LINK_W'(first_q);
			steps_q <= '0;
		end
		if (cmd.fw_step) begin
			cur_q   <= rdata;
			steps_q <= steps_q + STEP_W'(1);
		end
		if (cmd.out_load) begin
			out_status_q <= fail_q;
			out_first_q  <= fail_q ? LINK_FREE : LINK_W'(first_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - LINK_W - 1){1'b0}}, out_first_q, out_status_q};

endmodule

// ===== src/cluster_chain_allocator.sv =====
// ----------------------------------------------------------------------------
// cluster_chain_allocator
// FAT-style cluster chain allocator: builds and frees linked cluster chains
// in an on-chip link table.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of the link table and takes no
// item until that pass ends. An allocate item scans, for each cluster, the
// table entries from the rotating hint until a free one is found and links
// it into the chain; a failed allocate then walks and frees the partial
// chain. A free item walks the chain link by link, freeing each, and stops
// on the end-of-chain mark, an out-of-range link or the step limit. The pace
// is set by the single read port of the table: one entry is scanned or one
// link followed per read. A finished result is held in an output register,
// so the next item is taken while it waits to be read.
// ----------------------------------------------------------------------------
module cluster_chain_allocator
	import cca_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // alloc_count[12:0], start_cluster[28:13]
	input  logic                  s_tuser,  // func[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // status[0], first_link[16:1]
);

	cca_cmd_t  cmd;
	cca_stat_t stat;

	cca_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	cca_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

// ===== tb/sv/cca_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cca_tb_pkg
// Request and answer codes shared by the cluster chain allocator testbench
// top and its checker.
// ----------------------------------------------------------------------------
package cca_tb_pkg;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} cca_op_e;

	typedef enum logic {
		ST_OK       = 1'b0,
		ST_NO_SPACE = 1'b1
	} cca_status_e;

endpackage

// ===== tb/sv/cca_chain_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cca_chain_checker
// Watches both stream channels of the cluster chain allocator. Keeps its own
// copy of the link table and scan hint, works out the answer to every
// accepted request and compares each returned answer against the oldest one
// still owed, field by field.
// ----------------------------------------------------------------------------
module cca_chain_checker
	import cca_pkg::*;
	import cca_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // alloc_count[12:0], start_cluster[28:13]
	input  logic                  s_tuser,  // func[0]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,  // status[0], first_link[16:1]
	input  logic                  eot,
	output int                    fails
);

	typedef struct packed {
		cca_status_e       status;
		logic [LINK_W-1:0] first_link;
	} chain_answer_t;

	logic [LINK_W-1:0] link_map [CLUSTERS];
	logic [IDX_W-1:0]  scan_hint;
	chain_answer_t     owed_answers [$];
	int                answer_no;
	bit                eot_done;

	task automatic report(input string what, input int got, input int want);
		fails++;
		$display("[%0t] answer %0d %s: got 0x%0h, expected 0x%0h",
			$time, answer_no, what, got, want);
	endtask

	function automatic void clear_table();
		for (int i = 0; i < CLUSTERS; i++) begin
			link_map[i] = LINK_FREE;
		end
		scan_hint = '0;
	endfunction

	function automatic bit claim_cluster(output int found);
		int idx;
		for (int i = 0; i < CLUSTERS; i++) begin
			idx = (int'(scan_hint) + i) % CLUSTERS;
			if (link_map[idx] == LINK_FREE) begin
				scan_hint = IDX_W'((idx + 1) % CLUSTERS);
				found = idx;
				return 1'b1;
			end
		end
		found = 0;
		return 1'b0;
	endfunction

	function automatic void release_chain(input int first);
		int cur;
		int steps;
		logic [LINK_W-1:0] nxt;
		cur = first;
		steps = 0;
		while (cur != int'(LINK_EOC) && cur < CLUSTERS && steps < CLUSTERS) begin
			nxt = link_map[cur];
			link_map[cur] = LINK_FREE;
			if (nxt == LINK_EOC) begin
				break;
			end
			cur = int'(nxt);
			steps++;
		end
	endfunction

	function automatic void serve_request(input cca_op_e op, input int cnt, input int start,
		output chain_answer_t ans);
		int first;
		int prev;
		int idx;
		bit have;
		ans.status = ST_OK;
		ans.first_link = '0;
		if (op == OP_FREE) begin
			release_chain(start);
			return;
		end
		first = 0;
		prev = 0;
		have = 1'b0;
		for (int n = 0; n < cnt; n++) begin
			if (!claim_cluster(idx)) begin
				if (have) begin
					release_chain(first);
				end
				ans.status = ST_NO_SPACE;
				ans.first_link = '0;
				return;
			end
			link_map[idx] = LINK_EOC;
			if (have) begin
				link_map[prev] = LINK_W'(idx);
			end else begin
				first = idx;
				have = 1'b1;
			end
			prev = idx;
		end
		ans.first_link = LINK_W'(first);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chain_answer_t want;
		if (!arst_n) begin
			clear_table();
			owed_answers.delete();
			answer_no = 0;
			eot_done = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_answers.size() == 0) begin
					report("with no request pending", int'(m_tdata), 0);
				end else begin
					want = owed_answers.pop_front();
					if (m_tdata[0] !== want.status) begin
						report("status", int'(m_tdata[0]), int'(want.status));
					end
					if (m_tdata[16:1] !== want.first_link) begin
						report("first_link", int'(m_tdata[16:1]), int'(want.first_link));
					end
				end
				answer_no++;
			end
			if (s_tvalid && s_tready) begin
				serve_request(cca_op_e'(s_tuser), int'(s_tdata[COUNT_W-1:0]),
					int'(s_tdata[COUNT_W+LINK_W-1:COUNT_W]), want);
				owed_answers.push_back(want);
			end
			if (eot && !eot_done) begin
				eot_done = 1'b1;
				if (owed_answers.size() != 0) begin
					report("answers never returned", 0, owed_answers.size());
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb_cluster_chain_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cluster_chain_allocator
// Stimulus and verdict for the cluster chain allocator. A directed pass hits
// zero counts, exhaustion, oversized counts, a full table and odd free walks;
// a random pass then builds and frees chains in bursts, with some stray and
// repeated frees, while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_cluster_chain_allocator;
	import cca_pkg::*;
	import cca_tb_pkg::*;

	localparam int RANDOM_ITEMS = 2000;
	localparam int RUN_LIMIT    = 50000000;
	localparam int TAIL_CYCLES  = 64;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;  // alloc_count[12:0], start_cluster[28:13]
	logic                  s_tuser = 1'b0;  // func[0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;  // status[0], first_link[16:1]
	logic                  eot = 1'b0;
	int                    fails;

	int                items_sent = 0;
	int                results_seen = 0;
	int                cycles;
	bit                makes_chain [$];
	logic [LINK_W-1:0] chain_heads [$];
	logic [LINK_W-1:0] last_freed = '0;
	int                rx_mode = 0;
	int                rx_left = 0;

	always #4 clk = ~clk;

	cluster_chain_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	cca_chain_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.eot     (eot),
		.fails   (fails)
	);

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = (rx_mode == 3) ? $urandom_range(1, 24) : $urandom_range(1, 64);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (makes_chain.size() != 0) begin
				if (makes_chain.pop_front() && m_tdata[0] == ST_OK) begin
					chain_heads.push_back(m_tdata[16:1]);
				end
			end
		end
	end

	task automatic send_item(input cca_op_e op, input logic [COUNT_W-1:0] cnt,
		input logic [LINK_W-1:0] start);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_DATA_W'({start, cnt});
		do @(posedge clk); while (!s_tready);
		makes_chain.push_back(op == OP_ALLOC && cnt != '0);
		items_sent++;
	endtask

	task automatic idle_for(input int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
	endtask

	task automatic pick_item(output cca_op_e op, output logic [COUNT_W-1:0] cnt,
		output logic [LINK_W-1:0] start);
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (chain_heads.size() != 0 && (chain_heads.size() > 48 || r < 45)) begin
			k = $urandom_range(0, chain_heads.size() - 1);
			op = OP_FREE;
			start = chain_heads[k];
			chain_heads.delete(k);
			last_freed = start;
			cnt = COUNT_W'($urandom_range(0, 8191));
		end else if (r >= 45 && r < 49) begin
			op = OP_FREE;
			cnt = COUNT_W'($urandom_range(0, 8191));
			case ($urandom_range(0, 3))
				0: start = LINK_W'($urandom_range(CLUSTERS, 65535));
				1: start = LINK_EOC;
				2: start = LINK_W'($urandom_range(0, CLUSTERS - 1));
				default: start = last_freed;
			endcase
		end else begin
			op = OP_ALLOC;
			start = LINK_W'($urandom_range(0, 65535));
			k = $urandom_range(0, 99);
			if (k < 3) begin
				cnt = '0;
			end else if (k < 90) begin
				cnt = COUNT_W'($urandom_range(1, 12));
			end else if (k < 98) begin
				cnt = COUNT_W'($urandom_range(13, 300));
			end else begin
				cnt = COUNT_W'($urandom_range(0, 8191));
			end
		end
	endtask

	initial begin
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("cluster_chain_allocator regression: fail");
		$finish;
	end

	initial begin
		cca_op_e           op;
		logic [COUNT_W-1:0] cnt;
		logic [LINK_W-1:0]  start;
		int                 items_left;
		int                 burst;
		int                 sel;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(OP_ALLOC, '0, LINK_EOC);
		send_item(OP_ALLOC, COUNT_W'(1), '0);
		send_item(OP_ALLOC, COUNT_W'(CLUSTERS), LINK_W'(1));
		send_item(OP_ALLOC, '1, '1);
		send_item(OP_FREE, '1, LINK_EOC);
		send_item(OP_FREE, '0, LINK_W'(CLUSTERS));
		send_item(OP_ALLOC, COUNT_W'(CLUSTERS - 1), LINK_W'(16'h8000));
		send_item(OP_ALLOC, COUNT_W'(1), '0);
		send_item(OP_ALLOC, '0, '0);
		wait_results();
		while (chain_heads.size() != 0) begin
			send_item(OP_FREE, COUNT_W'(7), chain_heads.pop_front());
		end
		send_item(OP_FREE, '0, LINK_W'(5));
		send_item(OP_FREE, '1, LINK_W'(CLUSTERS - 1));
		send_item(OP_ALLOC, COUNT_W'(3), LINK_EOC);
		send_item(OP_ALLOC, COUNT_W'(2), '0);
		wait_results();
		send_item(OP_FREE, '0, chain_heads[0] + LINK_W'(1));
		send_item(OP_FREE, '0, chain_heads.pop_front());
		send_item(OP_FREE, '0, chain_heads.pop_front());
		send_item(OP_ALLOC, COUNT_W'(1), '1);

		items_left = RANDOM_ITEMS;
		while (items_left > 0) begin
			burst = $urandom_range(1, 16);
			for (int i = 0; i < burst && items_left > 0; i++) begin
				pick_item(op, cnt, start);
				send_item(op, cnt, start);
				items_left--;
			end
			sel = $urandom_range(0, 99);
			if (sel < 2) begin
				wait_results();
			end else if (sel >= 30) begin
				idle_for($urandom_range(1, 12));
			end
		end

		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		eot <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (fails == 0) begin
			$display("cluster_chain_allocator regression: pass");
		end else begin
			$display("cluster_chain_allocator regression: fail");
		end
		$finish;
	end

endmodule

// ===== cluster_chain_allocator.f =====
src/cca_pkg.sv
src/cca_ram.sv
src/cca_ctrl.sv
src/cca_dp.sv
src/cluster_chain_allocator.sv
tb/sv/cca_tb_pkg.sv
tb/sv/cca_chain_checker.sv
tb/sv/tb_cluster_chain_allocator.sv
